>>> hw/rtl/sm3_pkg.sv
package sm3_pkg;

  localparam logic [31:0] TLow  = 32'h79cc4519;
  localparam logic [31:0] THigh = 32'h7a879d8a;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam logic [5:0]  LenPos = 6'd56;

  typedef struct packed {
    logic [31:0] message_word;
    logic [2:0]  bytes_valid;
    logic        last_of_message;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_rsp_t;

  typedef logic [7:0][31:0] wvec_t;

  localparam wvec_t Iv = {32'hb0fb0e4e, 32'he38dee4d, 32'h163138aa, 32'ha96f30bc,
                          32'hda8a0600, 32'h172442d7, 32'h4914b2b9, 32'h7380166f};

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

>>> hw/rtl/sm3_round.sv
module sm3_round (
  input  sm3_pkg::wvec_t st_i,
  input  logic [31:0]    w0_i,
  input  logic [31:0]    w4_i,
  input  logic [5:0]     rnd_i,
  output sm3_pkg::wvec_t st_o
);
  logic        hi;
  logic [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2;
  logic [31:0] a, b, c, d, e, f, g, h;

  always_comb begin
    a = st_i[0]; b = st_i[1]; c = st_i[2]; d = st_i[3];
    e = st_i[4]; f = st_i[5]; g = st_i[6]; h = st_i[7];
    hi  = (rnd_i[5:4] != 2'b00);
    tj  = hi ? sm3_pkg::THigh : sm3_pkg::TLow;
    a12 = sm3_pkg::rotl(a, 5'd12);
    ss1 = sm3_pkg::rotl(a12 + e + sm3_pkg::rotl(tj, rnd_i[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (hi) begin
      ffv = (a & b) | (a & c) | (b & c);
      ggv = (e & f) | (~e & g);
    end else begin
      ffv = a ^ b ^ c;
      ggv = e ^ f ^ g;
    end
    tt1 = ffv + d + ss2 + (w0_i ^ w4_i);
    tt2 = ggv + h + ss1 + w0_i;
    st_o[0] = tt1;
    st_o[1] = a;
    st_o[2] = sm3_pkg::rotl(b, 5'd9);
    st_o[3] = c;
    st_o[4] = sm3_pkg::perm0(tt2);
    st_o[5] = e;
    st_o[6] = sm3_pkg::rotl(f, 5'd19);
    st_o[7] = g;
  end
endmodule

>>> hw/rtl/sm3_hash_engine_top.sv
// A word's valid bytes are written into the block buffer one at a time; each
// full block then takes a load plus 64 rounds, one round per cycle through one
// round unit. Final word: padding byte by byte up to 64 bytes, one or two block
// compressions, then eight digest requests, one per cycle while not stalled.
// A new word is accepted only in the idle state, once the previous one is done.
// Reset (rst_ni low, asynchronous): chaining value to IV, count and fill to zero.
module sm3_hash_engine_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  sm3_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output sm3_pkg::out_rsp_t out_rsp_o
);
  typedef enum logic [2:0] {
    StIdle, StLoad, StPad80, StPadZ, StLen, StInit, StComp, StOut
  } state_e;

  state_e         state_q, ret_q;
  sm3_pkg::wvec_t cv_q, wk_q, rnd_st;
  logic [15:0][31:0] buf_q;
  logic [60:0]    cnt_q;
  logic [5:0]     fill_q, rnd_q;
  logic [31:0]    word_q;
  logic [2:0]     nb_q, idx_q;
  logic           last_q;
  logic [63:0]    len_q;
  logic           bwe, shift;
  logic [7:0]     bbyte;
  logic [31:0]    wnew;
  logic [1:0]     lane;

  sm3_round u_round (
    .st_i (wk_q),
    .w0_i (buf_q[0]),
    .w4_i (buf_q[4]),
    .rnd_i(rnd_q),
    .st_o (rnd_st)
  );

  assign wnew = sm3_pkg::perm1(buf_q[0] ^ buf_q[7] ^ sm3_pkg::rotl(buf_q[13], 5'd15))
              ^ sm3_pkg::rotl(buf_q[3], 5'd7) ^ buf_q[10];
  assign lane = ~fill_q[1:0];

  always_comb begin
    bwe   = 1'b0;
    bbyte = 8'h00;
    case (state_q)
      StLoad: begin
        bwe   = (nb_q != 3'd0);
        bbyte = word_q[31:24];
      end
      StPad80: begin
        bwe   = 1'b1;
        bbyte = sm3_pkg::PadByte;
      end
      StPadZ: bwe = (fill_q != sm3_pkg::LenPos);
      StLen: begin
        bwe   = 1'b1;
        bbyte = len_q[63:56];
      end
      default: bwe = 1'b0;
    endcase
  end
  assign shift = (state_q == StComp);

  always_ff @(posedge clk_i) begin
    if (shift) begin
      buf_q <= {wnew, buf_q[15:1]};
    end else if (bwe) begin
      buf_q[fill_q[5:2]][{lane, 3'b000} +: 8] <= bbyte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ret_q   <= StIdle;
      cv_q    <= sm3_pkg::Iv;
      wk_q    <= '0;
      cnt_q   <= '0;
      fill_q  <= '0;
      rnd_q   <= '0;
      word_q  <= '0;
      nb_q    <= '0;
      last_q  <= 1'b0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      if (bwe) fill_q <= fill_q + 6'd1;
      case (state_q)
        StIdle: begin
          if (in_valid_i) begin
            word_q  <= in_req_i.message_word;
            nb_q    <= (in_req_i.bytes_valid > 3'd4) ? 3'd4 : in_req_i.bytes_valid;
            last_q  <= in_req_i.last_of_message;
            state_q <= StLoad;
          end
        end
        StLoad: begin
          if (nb_q != 3'd0) begin
            word_q <= {word_q[23:0], 8'h00};
            nb_q   <= nb_q - 3'd1;
            cnt_q  <= cnt_q + 61'd1;
            if (fill_q == 6'd63) begin
              ret_q   <= StLoad;
              state_q <= StInit;
            end
          end else begin
            state_q <= last_q ? StPad80 : StIdle;
          end
        end
        StPad80: begin
          len_q   <= {cnt_q, 3'b000};
          ret_q   <= StPadZ;
          state_q <= (fill_q == 6'd63) ? StInit : StPadZ;
        end
        StPadZ: begin
          if (fill_q == sm3_pkg::LenPos) begin
            state_q <= StLen;
          end else if (fill_q == 6'd63) begin
            ret_q   <= StPadZ;
            state_q <= StInit;
          end
        end
        StLen: begin
          len_q <= {len_q[55:0], 8'h00};
          if (fill_q == 6'd63) begin
            ret_q   <= StOut;
            state_q <= StInit;
          end
        end
        StInit: begin
          wk_q    <= cv_q;
          rnd_q   <= '0;
          state_q <= StComp;
        end
        StComp: begin
          wk_q  <= rnd_st;
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == 6'd63) begin
            cv_q    <= cv_q ^ rnd_st;
            idx_q   <= '0;
            state_q <= ret_q;
          end
        end
        StOut: begin
          if (!out_stall_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              cv_q    <= sm3_pkg::Iv;
              cnt_q   <= '0;
              fill_q  <= '0;
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign out_rsp_o.digest_word = cv_q[idx_q];
  assign out_rsp_o.word_index  = idx_q;
  assign out_rsp_o.last_word   = (idx_q == 3'd7);
endmodule

>>> hw/rtl/sm3_checker.sv
module sm3_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input sm3_pkg::out_rsp_t out_rsp_o
);
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o) else $error("not busy after request");

  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("input open during digest");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.last_word |-> out_rsp_o.word_index == 3'd7)
    else $error("last word index");

  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_rsp_o.last_word |=>
      out_valid_o && out_rsp_o.word_index == $past(out_rsp_o.word_index) + 3'd1)
    else $error("digest index step");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_rsp_o))
    else $error("stalled request changed");
endmodule

bind sm3_hash_engine_top sm3_checker u_sm3_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_rsp_o  (out_rsp_o)
);

>>> verif/sm3_hash_engine_top_tb.sv
`timescale 1ns / 100ps

module sm3_hash_engine_top_tb;

  localparam int unsigned WatchdogLimit = 20000;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  sm3_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  sm3_pkg::out_rsp_t out_rsp_o;

  sm3_hash_engine_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  logic [31:0]       hash_state [8];
  logic [31:0]       blk_words  [16];
  logic [60:0]       byte_count;
  int unsigned       blk_fill;
  sm3_pkg::out_rsp_t digest_q [$];
  int unsigned       n_errors = 0;
  int unsigned       idle_cycles;
  int unsigned       out_wait;
  bit                timed_out;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic logic [31:0] rl(input logic [31:0] x, input int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic hash_reset();
    logic [31:0] iv [8];
    iv = '{32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
           32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};
    for (int i = 0; i < 8; i++) hash_state[i] = iv[i];
    for (int i = 0; i < 16; i++) blk_words[i] = '0;
    byte_count = '0;
    blk_fill = 0;
  endtask

  task automatic compress_block();
    logic [31:0] w [68];
    logic [31:0] a, b, c, d, e, f, g, h, tj, a12, ss1, ss2, ff, gg, tt1, tt2, x;
    for (int j = 0; j < 16; j++) w[j] = blk_words[j];
    for (int j = 16; j < 68; j++) begin
      x = w[j-16] ^ w[j-9] ^ rl(w[j-3], 15);
      w[j] = x ^ rl(x, 15) ^ rl(x, 23) ^ rl(w[j-13], 7) ^ w[j-6];
    end
    {a, b, c, d} = {hash_state[0], hash_state[1], hash_state[2], hash_state[3]};
    {e, f, g, h} = {hash_state[4], hash_state[5], hash_state[6], hash_state[7]};
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? sm3_pkg::TLow : sm3_pkg::THigh;
      a12 = rl(a, 12);
      ss1 = rl(a12 + e + rl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + h + ss1 + w[j];
      d = c; c = rl(b, 9); b = a; a = tt1;
      h = g; g = rl(f, 19); f = e;
      e = tt2 ^ rl(tt2, 9) ^ rl(tt2, 17);
    end
    hash_state[0] ^= a; hash_state[1] ^= b; hash_state[2] ^= c; hash_state[3] ^= d;
    hash_state[4] ^= e; hash_state[5] ^= f; hash_state[6] ^= g; hash_state[7] ^= h;
  endtask

  task automatic put_byte(input int unsigned pos, input logic [7:0] v);
    blk_words[(pos >> 2) & 15][(3 - (pos & 3)) * 8 +: 8] = v;
  endtask

  task automatic predict_digest(input sm3_pkg::in_req_t req);
    int unsigned       nb;
    logic [63:0]       bits;
    sm3_pkg::out_rsp_t rsp;
    nb = (req.bytes_valid > 4) ? 4 : req.bytes_valid;
    for (int k = 0; k < nb; k++) begin
      put_byte(blk_fill, req.message_word[31 - 8*k -: 8]);
      blk_fill++;
      byte_count++;
      if (blk_fill == 64) begin
        compress_block();
        blk_fill = 0;
      end
    end
    if (req.last_of_message) begin
      put_byte(blk_fill, sm3_pkg::PadByte);
      for (int p = blk_fill + 1; p < 64; p++) put_byte(p, 8'h00);
      if (blk_fill >= 56) begin
        compress_block();
        for (int i = 0; i < 16; i++) blk_words[i] = '0;
      end
      bits = {byte_count, 3'b000};
      blk_words[14] = bits[63:32];
      blk_words[15] = bits[31:0];
      compress_block();
      for (int k = 0; k < 8; k++) begin
        rsp.digest_word = hash_state[k];
        rsp.word_index  = 3'(k);
        rsp.last_word   = (k == 7);
        digest_q.push_back(rsp);
      end
      hash_reset();
    end
  endtask

  task automatic send_word(input logic [31:0] word, input logic [2:0] nb, input bit last);
    int unsigned      gap;
    sm3_pkg::in_req_t req;
    gap = $urandom_range(0, 7);
    @(posedge clk_i);
    repeat (gap) @(posedge clk_i);
    req.message_word    = word;
    req.bytes_valid     = nb;
    req.last_of_message = last;
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    predict_digest(req);
    in_valid_i <= 1'b0;
  endtask

  task automatic send_message(input int unsigned nbytes);
    while (nbytes > 4) begin
      send_word($urandom, 3'd4, 1'b0);
      nbytes -= 4;
    end
    send_word($urandom, 3'(nbytes), 1'b1);
  endtask

  task automatic drain();
    while (digest_q.size() != 0 && !timed_out) @(posedge clk_i);
  endtask

  // output stall and checker
  always @(posedge clk_i) begin
    sm3_pkg::out_rsp_t want;
    int unsigned       wait_n;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      out_wait    <= 0;
      idle_cycles <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("unexpected digest word %h", out_rsp_o.digest_word);
          n_errors++;
        end else begin
          want = digest_q.pop_front();
          if (out_rsp_o.digest_word !== want.digest_word) begin
            $error("digest_word expected %h actual %h", want.digest_word,
                   out_rsp_o.digest_word);
            n_errors++;
          end
          if (out_rsp_o.word_index !== want.word_index) begin
            $error("word_index expected %0d actual %0d", want.word_index,
                   out_rsp_o.word_index);
            n_errors++;
          end
          if (out_rsp_o.last_word !== want.last_word) begin
            $error("last_word expected %0d actual %0d", want.last_word,
                   out_rsp_o.last_word);
            n_errors++;
          end
        end
        wait_n = $urandom_range(0, 7);
        out_stall_i <= (wait_n != 0);
        out_wait    <= (wait_n != 0) ? wait_n - 1 : 0;
      end else if (out_wait != 0) begin
        out_wait <= out_wait - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_directed();
    send_word(32'h0, 3'd0, 1'b1);                   // empty message
    send_word(32'h61626300, 3'd3, 1'b1);            // "abc"
    send_word(32'hffffffff, 3'd4, 1'b1);
    send_word(32'h12345678, 3'd7, 1'b0);            // oversized count
    send_word(32'hdeadbeef, 3'd5, 1'b0);
    send_word(32'haabbccdd, 3'd1, 1'b0);            // partial not last
    send_word(32'h11223344, 3'd2, 1'b0);
    send_word(32'h55667788, 3'd6, 1'b1);
    send_message(55);
    send_message(56);
    send_message(64);
  endtask

  task automatic test_stall_pause();
    drain();
    send_message(4);
    drain();
  endtask

  task automatic test_random();
    int unsigned sent;
    int unsigned len;
    int unsigned n_extra;
    sent = 0;
    while (sent < 57) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 140) : $urandom_range(0, 30);
      sent += (len == 0) ? 1 : (len + 3) / 4;
      if ($urandom_range(0, 4) == 0) begin
        n_extra = $urandom_range(1, 4);
        sent += n_extra;
        repeat (n_extra) begin
          send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
        end
      end
      send_message(len);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    hash_reset();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_stall_pause();
    test_random();
    drain();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && digest_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/sm3_pkg.sv
hw/rtl/sm3_round.sv
hw/rtl/sm3_hash_engine_top.sv
hw/rtl/sm3_checker.sv
verif/sm3_hash_engine_top_tb.sv
